// ===== rtl/core/rfsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsb_pkg: shared definitions of the real FFT split butterfly
// Default widths, gain format, register indexes, pair kinds and the control
// word that travels with every stage of the pipeline.
// ----------------------------------------------------------------------------
package rfsb_pkg;

    // Default data and twiddle widths.
    localparam int DATA_WIDTH_DEF    = 24;
    localparam int TWIDDLE_WIDTH_DEF = 16;

    // Gain register: unsigned Q2.16.
    localparam int               GAIN_WIDTH = 18;
    localparam int               GAIN_FRAC  = 16;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 18'd131072;
    localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = 18'd65536;

    // Configuration register indexes.
    localparam int CFG_ADDR_WIDTH = 1;
    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_INVERSE = 1'b0,
        CFG_GAIN    = 1'b1
    } t_cfg_idx;

    // Pair kind carried in tuser; the fourth code is reserved and yields zeros.
    localparam int FUNC_WIDTH = 2;
    typedef enum logic [FUNC_WIDTH-1:0] {
        FUNC_EDGE = 2'd0,
        FUNC_PAIR = 2'd1,
        FUNC_MID  = 2'd2
    } t_func;

    // Control word of one pipeline stage.
    typedef struct packed {
        logic  valid;
        t_func func;
    } t_stage;

endpackage

// ===== rtl/core/rfsb_pre.sv =====
// ----------------------------------------------------------------------------
// rfsb_pre: input stage with pre-adders
// Registers the accepted word together with the sums and differences that the
// twiddle products and the edge and middle kinds need.
// ----------------------------------------------------------------------------
module rfsb_pre #(
    parameter int DATA_WIDTH    = rfsb_pkg::DATA_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = rfsb_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [rfsb_pkg::FUNC_WIDTH-1:0]  i_func,
    input  logic signed [DATA_WIDTH-1:0]     i_a,
    input  logic signed [DATA_WIDTH-1:0]     i_b,
    input  logic signed [DATA_WIDTH-1:0]     i_c,
    input  logic signed [DATA_WIDTH-1:0]     i_d,
    input  logic signed [DATA_WIDTH-1:0]     i_n,
    input  logic signed [TWIDDLE_WIDTH-1:0]  i_tc,
    input  logic signed [TWIDDLE_WIDTH-1:0]  i_ts,
    output logic                             o_ready,
    input  logic                             i_adv,
    output rfsb_pkg::t_stage                 o_st,
    output logic signed [DATA_WIDTH:0]       o_sac,
    output logic signed [DATA_WIDTH:0]       o_dac,
    output logic signed [DATA_WIDTH:0]       o_sbd,
    output logic signed [DATA_WIDTH:0]       o_dbd,
    output logic signed [DATA_WIDTH:0]       o_fsum,
    output logic signed [DATA_WIDTH:0]       o_fdif,
    output logic signed [DATA_WIDTH+1:0]     o_e0,
    output logic signed [DATA_WIDTH+1:0]     o_e1,
    output logic signed [DATA_WIDTH-1:0]     o_a,
    output logic signed [DATA_WIDTH-1:0]     o_b,
    output logic signed [DATA_WIDTH:0]       o_nb,
    output logic signed [TWIDDLE_WIDTH-1:0]  o_tc,
    output logic signed [TWIDDLE_WIDTH-1:0]  o_ts
);

    localparam int W1 = DATA_WIDTH + 1;
    localparam int W2 = DATA_WIDTH + 2;

    rfsb_pkg::t_stage                r_st;
    logic signed [DATA_WIDTH:0]      r_sac, r_dac, r_sbd, r_dbd, r_fsum, r_fdif, r_nb;
    logic signed [DATA_WIDTH+1:0]    r_e0, r_e1;
    logic signed [DATA_WIDTH-1:0]    r_a, r_b;
    logic signed [TWIDDLE_WIDTH-1:0] r_tc, r_ts;

    // The stage takes a word when it is empty or its content moves on.
    assign o_ready = !r_st.valid || i_adv;

    // Valid and kind of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (o_ready) begin
            r_st.valid <= i_valid;
            r_st.func  <= rfsb_pkg::t_func'(i_func);
        end
    end

    // Pre-adders: butterfly sums and differences, edge combinations.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sac  <= W1'(i_a) + W1'(i_c);
            r_dac  <= W1'(i_a) - W1'(i_c);
            r_sbd  <= W1'(i_b) + W1'(i_d);
            r_dbd  <= W1'(i_b) - W1'(i_d);
            r_fsum <= W1'(i_a) + W1'(i_b);
            r_fdif <= W1'(i_a) - W1'(i_b);
            r_e0   <= W2'(i_a) - W2'(i_b) + W2'(i_n);
            r_e1   <= W2'(i_n) - W2'(i_a) - W2'(i_b);
            r_nb   <= -W1'(i_b);
            r_a    <= i_a;
            r_b    <= i_b;
            r_tc   <= i_tc;
            r_ts   <= i_ts;
        end
    end

    assign o_st   = r_st;
    assign o_sac  = r_sac;
    assign o_dac  = r_dac;
    assign o_sbd  = r_sbd;
    assign o_dbd  = r_dbd;
    assign o_fsum = r_fsum;
    assign o_fdif = r_fdif;
    assign o_e0   = r_e0;
    assign o_e1   = r_e1;
    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_nb   = r_nb;
    assign o_tc   = r_tc;
    assign o_ts   = r_ts;

`ifndef NO_ASSERTIONS
    // An accepted word occupies the stage on the next cycle.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_st.valid)
        else $error("input stage lost an accepted word");
`endif

endmodule

// ===== rtl/core/rfsb_twiddle.sv =====
// ----------------------------------------------------------------------------
// rfsb_twiddle: twiddle products and butterfly sums
// One stage forms the four twiddle products, the next adds them to the half
// sums, rounds to integer and selects the lane values for the gain stage.
// ----------------------------------------------------------------------------
module rfsb_twiddle #(
    parameter int DATA_WIDTH    = rfsb_pkg::DATA_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = rfsb_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_inverse,
    input  rfsb_pkg::t_stage                 i_st,
    input  logic signed [DATA_WIDTH:0]       i_sac,
    input  logic signed [DATA_WIDTH:0]       i_dac,
    input  logic signed [DATA_WIDTH:0]       i_sbd,
    input  logic signed [DATA_WIDTH:0]       i_dbd,
    input  logic signed [DATA_WIDTH:0]       i_fsum,
    input  logic signed [DATA_WIDTH:0]       i_fdif,
    input  logic signed [DATA_WIDTH+1:0]     i_e0,
    input  logic signed [DATA_WIDTH+1:0]     i_e1,
    input  logic signed [DATA_WIDTH-1:0]     i_a,
    input  logic signed [DATA_WIDTH-1:0]     i_b,
    input  logic signed [DATA_WIDTH:0]       i_nb,
    input  logic signed [TWIDDLE_WIDTH-1:0]  i_tc,
    input  logic signed [TWIDDLE_WIDTH-1:0]  i_ts,
    output logic                             o_ready,
    input  logic                             i_adv,
    output rfsb_pkg::t_stage                 o_st,
    output logic signed [DATA_WIDTH+3:0]     o_l0,
    output logic signed [DATA_WIDTH+3:0]     o_l1,
    output logic signed [DATA_WIDTH+3:0]     o_l2,
    output logic signed [DATA_WIDTH+3:0]     o_l3,
    output logic signed [DATA_WIDTH:0]       o_l4
);

    localparam int W1 = DATA_WIDTH + 1;
    localparam int PW = DATA_WIDTH + TWIDDLE_WIDTH + 1;   // twiddle product
    localparam int AW = DATA_WIDTH + TWIDDLE_WIDTH + 2;   // butterfly sum
    localparam int VW = DATA_WIDTH + 4;                   // lane value
    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (TWIDDLE_WIDTH - 2);

    rfsb_pkg::t_stage       r_st2, r_st3;
    logic                   adv2, adv3;
    logic signed [PW-1:0]   r_pa, r_pb, r_pc, r_pd;
    logic signed [W1-1:0]   r_sac, r_dbd, r_fsum, r_fdif, r_nb;
    logic signed [W1:0]     r_e0, r_e1;
    logic signed [DATA_WIDTH-1:0] r_a, r_b;
    logic signed [VW-1:0]   r_l0, r_l1, r_l2, r_l3, n_l0, n_l1, n_l2, n_l3;
    logic signed [W1-1:0]   r_l4, n_l4;
    logic signed [AW-1:0]   p_half, q_half, s0, s1, s2, s3, t0, t1, t2, t3;

    // Stage enables, each stage moves when it is empty or the next one takes.
    assign adv3    = !r_st3.valid || i_adv;
    assign adv2    = !r_st2.valid || adv3;
    assign o_ready = adv2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st2 <= '0;
            r_st3 <= '0;
        end else begin
            if (adv2) begin
                r_st2 <= i_st;
            end
            if (adv3) begin
                r_st3 <= r_st2;
            end
        end
    end

    // Product stage: the four twiddle products.
    always_ff @(posedge i_clk) begin
        if (adv2 && i_st.valid) begin
            r_pa   <= i_tc * i_sbd;
            r_pb   <= i_ts * i_dac;
            r_pc   <= i_tc * i_dac;
            r_pd   <= i_ts * i_sbd;
            r_sac  <= i_sac;
            r_dbd  <= i_dbd;
            r_fsum <= i_fsum;
            r_fdif <= i_fdif;
            r_e0   <= i_e0;
            r_e1   <= i_e1;
            r_a    <= i_a;
            r_b    <= i_b;
            r_nb   <= i_nb;
        end
    end

    // Butterfly sums; the half weight of the plain terms is a shift.
    always_comb begin
        p_half = AW'(r_sac) <<< (TWIDDLE_WIDTH - 2);
        q_half = AW'(r_dbd) <<< (TWIDDLE_WIDTH - 2);
        if (i_inverse) begin
            s0 = p_half - AW'(r_pa) - AW'(r_pb);
            s1 = -q_half - AW'(r_pc) + AW'(r_pd);
            s2 = p_half + AW'(r_pa) + AW'(r_pb);
            s3 = q_half - AW'(r_pc) + AW'(r_pd);
        end else begin
            s0 = p_half + AW'(r_pa) - AW'(r_pb);
            s1 = q_half - AW'(r_pc) - AW'(r_pd);
            s2 = p_half - AW'(r_pa) + AW'(r_pb);
            s3 = -q_half - AW'(r_pc) - AW'(r_pd);
        end
        // Round half up to integer.
        t0 = (s0 + HALF) >>> (TWIDDLE_WIDTH - 1);
        t1 = (s1 + HALF) >>> (TWIDDLE_WIDTH - 1);
        t2 = (s2 + HALF) >>> (TWIDDLE_WIDTH - 1);
        t3 = (s3 + HALF) >>> (TWIDDLE_WIDTH - 1);
    end

    // Lane selection by pair kind; unused lanes and the reserved kind give zero.
    always_comb begin
        n_l0 = '0;
        n_l1 = '0;
        n_l2 = '0;
        n_l3 = '0;
        n_l4 = '0;
        case (r_st2.func)
            rfsb_pkg::FUNC_EDGE: begin
                if (i_inverse) begin
                    n_l0 = VW'(r_e0);
                    n_l1 = VW'(r_e1);
                end else begin
                    n_l0 = VW'(r_fsum);
                    n_l4 = r_fdif;
                end
            end
            rfsb_pkg::FUNC_PAIR: begin
                n_l0 = $signed(t0[VW-1:0]);
                n_l1 = $signed(t1[VW-1:0]);
                n_l2 = $signed(t2[VW-1:0]);
                n_l3 = $signed(t3[VW-1:0]);
            end
            rfsb_pkg::FUNC_MID: begin
                n_l0 = VW'(r_a);
                n_l1 = i_inverse ? VW'(r_b) : VW'(r_nb);
            end
            default: begin
                n_l0 = '0;
            end
        endcase
    end

    // Sum stage registers.
    always_ff @(posedge i_clk) begin
        if (adv3 && r_st2.valid) begin
            r_l0 <= n_l0;
            r_l1 <= n_l1;
            r_l2 <= n_l2;
            r_l3 <= n_l3;
            r_l4 <= n_l4;
        end
    end

    assign o_st = r_st3;
    assign o_l0 = r_l0;
    assign o_l1 = r_l1;
    assign o_l2 = r_l2;
    assign o_l3 = r_l3;
    assign o_l4 = r_l4;

`ifndef NO_ASSERTIONS
    // A stalled sum stage keeps its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st3.valid && !i_adv) |=> (r_st3.valid && $stable(r_l0) && $stable(r_l4)))
        else $error("sum stage changed while stalled");
    // Only the edge kind carries a Nyquist value.
    a_nyq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st3.valid && r_st3.func != rfsb_pkg::FUNC_EDGE) |-> (r_l4 == '0))
        else $error("Nyquist lane set for a non-edge pair");
`endif

endmodule

// ===== rtl/core/rfsb_scale.sv =====
// ----------------------------------------------------------------------------
// rfsb_scale: gain multiply, rounding and saturation
// Multiplies the four lane values by the inverse gain (unity in forward mode),
// then rounds, saturates them and the unscaled Nyquist lane to the data range
// and holds the result word for the output port.
module rfsb_scale #(
    parameter int DATA_WIDTH = rfsb_pkg::DATA_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_inverse,
    input  logic [rfsb_pkg::GAIN_WIDTH-1:0]      i_gain,
    input  rfsb_pkg::t_stage                     i_st,
    input  logic signed [DATA_WIDTH+3:0]         i_l0,
    input  logic signed [DATA_WIDTH+3:0]         i_l1,
    input  logic signed [DATA_WIDTH+3:0]         i_l2,
    input  logic signed [DATA_WIDTH+3:0]         i_l3,
    input  logic signed [DATA_WIDTH:0]           i_l4,
    output logic                                 o_ready,
    input  logic                                 i_adv,
    output logic                                 o_valid,
    output logic [DATA_WIDTH-1:0]                o_r0,
    output logic [DATA_WIDTH-1:0]                o_r1,
    output logic [DATA_WIDTH-1:0]                o_r2,
    output logic [DATA_WIDTH-1:0]                o_r3,
    output logic [DATA_WIDTH-1:0]                o_r4,
    output logic                                 o_sat
);

    localparam int GW = rfsb_pkg::GAIN_WIDTH;
    localparam int VW = DATA_WIDTH + 4;
    localparam int MW = VW + GW + 1;
    localparam logic signed [MW-1:0] H_STD  = MW'(1) <<< (rfsb_pkg::GAIN_FRAC - 1);
    localparam logic signed [MW-1:0] H_EDGE = MW'(1) <<< rfsb_pkg::GAIN_FRAC;
    localparam logic signed [MW-1:0] DMAX   = (MW'(1) <<< (DATA_WIDTH - 1)) - MW'(1);
    localparam logic signed [MW-1:0] DMIN   = -DMAX - MW'(1);

    rfsb_pkg::t_stage          r_st4;
    logic                      r_v5, adv4, adv5, edge_shift;
    logic signed [GW:0]        g_s;
    logic signed [MW-1:0]      r_m0, r_m1, r_m2, r_m3;
    logic signed [MW-1:0]      x0, x1, x2, x3;
    logic signed [DATA_WIDTH:0] r_l4;
    logic [DATA_WIDTH:0]       c0, c1, c2, c3, c4;
    logic [DATA_WIDTH-1:0]     r_r0, r_r1, r_r2, r_r3, r_r4;
    logic                      r_sat;

    // Saturate to the data range; the top bit of the result flags clipping.
    function automatic logic [DATA_WIDTH:0] clip_w(input logic signed [MW-1:0] x);
        logic [DATA_WIDTH:0] res;
        if (x > DMAX) begin
            res = {1'b1, DMAX[DATA_WIDTH-1:0]};
        end else if (x < DMIN) begin
            res = {1'b1, DMIN[DATA_WIDTH-1:0]};
        end else begin
            res = {1'b0, x[DATA_WIDTH-1:0]};
        end
        return res;
    endfunction

    assign adv5    = !r_v5 || i_adv;
    assign adv4    = !r_st4.valid || adv5;
    assign o_ready = adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st4 <= '0;
            r_v5  <= 1'b0;
        end else begin
            if (adv4) begin
                r_st4 <= i_st;
            end
            if (adv5) begin
                r_v5 <= r_st4.valid;
            end
        end
    end

    // Gain stage: forward words pass with unity gain, which is exact.
    assign g_s = $signed({1'b0, (i_inverse ? i_gain : rfsb_pkg::GAIN_UNITY)});

    always_ff @(posedge i_clk) begin
        if (adv4 && i_st.valid) begin
            r_m0 <= i_l0 * g_s;
            r_m1 <= i_l1 * g_s;
            r_m2 <= i_l2 * g_s;
            r_m3 <= i_l3 * g_s;
            r_l4 <= i_l4;
        end
    end

    // Inverse edge words carry an extra halving in the rounding shift.
    assign edge_shift = i_inverse && (r_st4.func == rfsb_pkg::FUNC_EDGE);

    always_comb begin
        if (edge_shift) begin
            x0 = (r_m0 + H_EDGE) >>> (rfsb_pkg::GAIN_FRAC + 1);
            x1 = (r_m1 + H_EDGE) >>> (rfsb_pkg::GAIN_FRAC + 1);
            x2 = (r_m2 + H_EDGE) >>> (rfsb_pkg::GAIN_FRAC + 1);
            x3 = (r_m3 + H_EDGE) >>> (rfsb_pkg::GAIN_FRAC + 1);
        end else begin
            x0 = (r_m0 + H_STD) >>> rfsb_pkg::GAIN_FRAC;
            x1 = (r_m1 + H_STD) >>> rfsb_pkg::GAIN_FRAC;
            x2 = (r_m2 + H_STD) >>> rfsb_pkg::GAIN_FRAC;
            x3 = (r_m3 + H_STD) >>> rfsb_pkg::GAIN_FRAC;
        end
        c0 = clip_w(x0);
        c1 = clip_w(x1);
        c2 = clip_w(x2);
        c3 = clip_w(x3);
        c4 = clip_w(MW'(r_l4));
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (adv5 && r_st4.valid) begin
            r_r0  <= c0[DATA_WIDTH-1:0];
            r_r1  <= c1[DATA_WIDTH-1:0];
            r_r2  <= c2[DATA_WIDTH-1:0];
            r_r3  <= c3[DATA_WIDTH-1:0];
            r_r4  <= c4[DATA_WIDTH-1:0];
            r_sat <= c0[DATA_WIDTH] | c1[DATA_WIDTH] | c2[DATA_WIDTH]
                   | c3[DATA_WIDTH] | c4[DATA_WIDTH];
        end
    end

    assign o_valid = r_v5;
    assign o_r0    = r_r0;
    assign o_r1    = r_r1;
    assign o_r2    = r_r2;
    assign o_r3    = r_r3;
    assign o_r4    = r_r4;
    assign o_sat   = r_sat;

`ifndef NO_ASSERTIONS
    // A word leaving the gain stage lands in the output register.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st4.valid && adv5) |=> r_v5)
        else $error("gain stage word dropped");
`endif

endmodule

// ===== rtl/core/real_fft_split_butterfly_core.sv =====
// ----------------------------------------------------------------------------
// real_fft_split_butterfly_core: real FFT split and merge butterfly
// Turns bin pairs of a half-length complex FFT into real FFT bins (forward) or
// prepares a half spectrum for a real inverse FFT with a programmable gain.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output is not stalled and returns
// one result word per input word. The five register stages are the pre-adders,
// the twiddle multipliers, the butterfly adders with rounding, the gain
// multipliers, and rounding with saturation into the output register; each
// stage holds one word, so a stall at the output fills the empty stages before
// tready falls. Write the two registers only while no word is in flight.
module real_fft_split_butterfly_core #(
    parameter int DATA_WIDTH    = rfsb_pkg::DATA_WIDTH_DEF,
    parameter int TWIDDLE_WIDTH = rfsb_pkg::TWIDDLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration write port.
    input  logic                                  i_cfg_we,
    input  logic [rfsb_pkg::CFG_ADDR_WIDTH-1:0]   i_cfg_addr,
    input  logic [rfsb_pkg::GAIN_WIDTH-1:0]       i_cfg_data,
    // Input stream.
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata, low bit up: lo_re, lo_im, hi_re, hi_im, nyquist_in, tw_cos, tw_sin
    input  logic [((5*DATA_WIDTH+2*TWIDDLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // tuser: func
    input  logic [rfsb_pkg::FUNC_WIDTH-1:0]       i_s_axis_tuser,
    // Output stream.
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata, low bit up: lo_re_out, lo_im_out, hi_re_out, hi_im_out, nyquist_out
    output logic [((5*DATA_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,
    // tuser: saturated
    output logic                                  o_m_axis_tuser
);

    localparam int W       = DATA_WIDTH;
    localparam int T       = TWIDDLE_WIDTH;
    localparam int OUT_TDW = ((5*DATA_WIDTH+7)/8)*8;

    logic                        r_inverse;
    logic [rfsb_pkg::GAIN_WIDTH-1:0] r_gain;

    rfsb_pkg::t_stage            st1, st3;
    logic                        rdy2, rdy4;
    logic signed [W:0]           sac, dac, sbd, dbd, fsum, fdif, nb;
    logic signed [W+1:0]         e0, e1;
    logic signed [W-1:0]         pa, pb;
    logic signed [T-1:0]         tc, ts;
    logic signed [W+3:0]         l0, l1, l2, l3;
    logic signed [W:0]           l4;
    logic [W-1:0]                r0, r1, r2, r3, r4;
    logic                        sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_gain    <= rfsb_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            case (rfsb_pkg::t_cfg_idx'(i_cfg_addr))
                rfsb_pkg::CFG_INVERSE: r_inverse <= i_cfg_data[0];
                rfsb_pkg::CFG_GAIN:    r_gain    <= i_cfg_data;
                default:               r_gain    <= r_gain;
            endcase
        end
    end

    // Pre-adder stage.
    rfsb_pre #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_func  (i_s_axis_tuser),
        .i_a     ($signed(i_s_axis_tdata[W-1:0])),
        .i_b     ($signed(i_s_axis_tdata[2*W-1:W])),
        .i_c     ($signed(i_s_axis_tdata[3*W-1:2*W])),
        .i_d     ($signed(i_s_axis_tdata[4*W-1:3*W])),
        .i_n     ($signed(i_s_axis_tdata[5*W-1:4*W])),
        .i_tc    ($signed(i_s_axis_tdata[5*W+T-1:5*W])),
        .i_ts    ($signed(i_s_axis_tdata[5*W+2*T-1:5*W+T])),
        .o_ready (o_s_axis_tready),
        .i_adv   (rdy2),
        .o_st    (st1),
        .o_sac   (sac),
        .o_dac   (dac),
        .o_sbd   (sbd),
        .o_dbd   (dbd),
        .o_fsum  (fsum),
        .o_fdif  (fdif),
        .o_e0    (e0),
        .o_e1    (e1),
        .o_a     (pa),
        .o_b     (pb),
        .o_nb    (nb),
        .o_tc    (tc),
        .o_ts    (ts)
    );

    // Twiddle product and butterfly sum stages.
    rfsb_twiddle #(
        .DATA_WIDTH    (DATA_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_twiddle (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inverse (r_inverse),
        .i_st      (st1),
        .i_sac     (sac),
        .i_dac     (dac),
        .i_sbd     (sbd),
        .i_dbd     (dbd),
        .i_fsum    (fsum),
        .i_fdif    (fdif),
        .i_e0      (e0),
        .i_e1      (e1),
        .i_a       (pa),
        .i_b       (pb),
        .i_nb      (nb),
        .i_tc      (tc),
        .i_ts      (ts),
        .o_ready   (rdy2),
        .i_adv     (rdy4),
        .o_st      (st3),
        .o_l0      (l0),
        .o_l1      (l1),
        .o_l2      (l2),
        .o_l3      (l3),
        .o_l4      (l4)
    );

    // Gain, rounding and saturation stages.
    rfsb_scale #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_inverse (r_inverse),
        .i_gain    (r_gain),
        .i_st      (st3),
        .i_l0      (l0),
        .i_l1      (l1),
        .i_l2      (l2),
        .i_l3      (l3),
        .i_l4      (l4),
        .o_ready   (rdy4),
        .i_adv     (i_m_axis_tready),
        .o_valid   (o_m_axis_tvalid),
        .o_r0      (r0),
        .o_r1      (r1),
        .o_r2      (r2),
        .o_r3      (r3),
        .o_r4      (r4),
        .o_sat     (sat)
    );

    // Output word packing.
    assign o_m_axis_tdata = OUT_TDW'({r4, r3, r2, r1, r0});
    assign o_m_axis_tuser = sat;

endmodule
